// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset
`define SED_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sed assertion failed");

// Check that a condition never holds outside reset
`define SED_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sed forbidden condition seen");

`else

`define SED_ASSERT(label, clk, rst, prop)
`define SED_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// File: hw/rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// Shake energy detector package
// Widths, reset values, register indexes, result codes and shared types.
// ----------------------------------------------------------------------------
package sed_pkg;

   // Field widths
   localparam int VEL_W      = 16;
   localparam int TICK_W     = 16;
   localparam int TIME_W     = 32;
   localparam int ENERGY_W   = 32;
   localparam int RATE_W     = 16;
   localparam int STATE_W    = 2;

   // Sum of squares and its root (radicand is the sum shifted up 16 bits)
   localparam int SQ_W       = 2 * VEL_W;
   localparam int ROOT_W     = 24;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int SQ_STEPS   = VEL_W;
   localparam int CNT_W      = 5;

   // Stream and register port widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [ENERGY_W-1:0] THRESHOLD_RESET = 32'd2560000;
   localparam logic [RATE_W-1:0]   DECAY_RESET     = 16'd256;
   localparam logic [TIME_W-1:0]   COOLDOWN_RESET  = 32'd1000;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_DECAY     = 2'd1,
      CSR_COOLDOWN  = 2'd2
   } csr_index_type;

   // Result codes
   typedef enum logic [STATE_W-1:0] {
      TRIG_NONE    = 2'd0,
      TRIG_ONGOING = 2'd1,
      TRIG_FIRED   = 2'd2
   } trig_state_type;

   // Control of a serial arithmetic unit
   typedef struct packed {
      logic load;
      logic step;
   } seq_ctl_type;

endpackage

// File: hw/rtl/shake_energy_detector.sv
// ----------------------------------------------------------------------------
// Shake energy detector
// Leaky energy integrator with a trigger threshold and a cooldown window.
// ----------------------------------------------------------------------------
// One item is handled at a time: it is accepted only while the block is idle,
// and the next item is not accepted until its result is loaded into the
// output register. The steps are the bit-serial squaring of both velocity
// components (run side by side with the leak product), the bit-serial square
// root of the 48-bit radicand (one load step plus 24 steps), then the
// saturating add, the leak and the threshold decision. A finished result may
// sit in the output register while the next item is already accepted; the
// decision step waits only if that register is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shake_energy_detector (
   input  logic                               clock,
   input  logic                               reset,
   // Items in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vel_x[15:0], vel_y[31:16], elapsed_ticks[47:32], now_ticks[79:48]
   input  logic [sed_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Results out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // trigger_state[1:0], energy_level[33:2], zero fill above
   output logic [sed_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Register writes
   input  logic                               csr_wr_en,
   input  logic [sed_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sed_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_ROOT   = 6'b000100,
      ST_SUM    = 6'b001000,
      ST_LEAK   = 6'b010000,
      ST_DECIDE = 6'b100000
   } fsm_type;

   localparam int ENERGY_W = sed_pkg::ENERGY_W;
   localparam int VEL_W    = sed_pkg::VEL_W;

   // Request fields
   logic signed [VEL_W-1:0]          req_vel_x, req_vel_y;
   logic [sed_pkg::TICK_W-1:0]       req_elapsed;
   logic [sed_pkg::TIME_W-1:0]       req_now;
   logic [VEL_W-1:0]                 abs_x, abs_y;
   logic                             req_fire;

   // Configuration
   logic [ENERGY_W-1:0]              thresh_ff, thresh_in;
   logic [sed_pkg::RATE_W-1:0]       decay_ff, decay_in;
   logic [sed_pkg::TIME_W-1:0]       cool_len_ff, cool_len_in;

   // Detector state
   logic [ENERGY_W-1:0]              energy_ff, energy_in;
   logic [sed_pkg::TIME_W-1:0]       last_trig_ff, last_trig_in;
   logic                             has_trig_ff, has_trig_in;

   // Sequencer and work registers
   fsm_type                          state_ff, state_in;
   logic [sed_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [sed_pkg::TIME_W-1:0]       now_ff, now_in;
   logic                             cool_ff, cool_in;
   logic [ENERGY_W-1:0]              base_ff, base_in;
   logic [ENERGY_W-1:0]              leaked_ff, leaked_in;

   // Output register
   logic                             rsp_valid_ff, rsp_valid_in;
   sed_pkg::trig_state_type          rsp_state_ff, rsp_state_in;
   logic [ENERGY_W-1:0]              rsp_energy_ff, rsp_energy_in;

   // Arithmetic units
   sed_pkg::seq_ctl_type             mul_ctl, root_ctl;
   logic [2*VEL_W-1:0]               sq_x, sq_y;
   logic [2*sed_pkg::RATE_W-1:0]     leak_amount;
   logic [sed_pkg::SQ_W-1:0]         sq_sum;
   logic [sed_pkg::ROOT_W-1:0]       root;

   // Combinational helpers
   logic [sed_pkg::TIME_W-1:0]       since_trig;
   logic [ENERGY_W:0]                acc_sum;
   logic                             out_load;
   logic                             fire;

   // Unpack the request
   assign req_vel_x   = req_tdata[VEL_W-1:0];
   assign req_vel_y   = req_tdata[2*VEL_W-1:VEL_W];
   assign req_elapsed = req_tdata[2*VEL_W+sed_pkg::TICK_W-1:2*VEL_W];
   assign req_now     = req_tdata[sed_pkg::REQ_DATA_W-1:2*VEL_W+sed_pkg::TICK_W];
   assign abs_x       = req_vel_x[VEL_W-1] ? VEL_W'(-req_vel_x) : req_vel_x;
   assign abs_y       = req_vel_y[VEL_W-1] ? VEL_W'(-req_vel_y) : req_vel_y;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign out_load    = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_tready);

   // Drive the serial units
   always_comb begin
      mul_ctl.load  = req_fire;
      mul_ctl.step  = (state_ff == ST_SQUARE);
      root_ctl.load = (state_ff == ST_ROOT) && (cnt_ff == '0);
      root_ctl.step = (state_ff == ST_ROOT) && (cnt_ff != '0);
   end

   sed_mul_serial #(.WIDTH(VEL_W)) u_sq_x (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (abs_x),
      .multiplier   (abs_x),
      .product      (sq_x)
   );

   sed_mul_serial #(.WIDTH(VEL_W)) u_sq_y (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (abs_y),
      .multiplier   (abs_y),
      .product      (sq_y)
   );

   sed_mul_serial #(.WIDTH(sed_pkg::RATE_W)) u_leak (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (decay_ff),
      .multiplier   (req_elapsed),
      .product      (leak_amount)
   );

   assign sq_sum = sq_x + sq_y;

   sed_isqrt_serial u_root (
      .clock    (clock),
      .ctl      (root_ctl),
      .radicand (sq_sum),
      .root     (root)
   );

   // Register writes; an index past the list is dropped
   always_comb begin
      thresh_in   = thresh_ff;
      decay_in    = decay_ff;
      cool_len_in = cool_len_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sed_pkg::CSR_THRESHOLD: thresh_in   = csr_wr_data;
            sed_pkg::CSR_DECAY:     decay_in    = csr_wr_data[sed_pkg::RATE_W-1:0];
            sed_pkg::CSR_COOLDOWN:  cool_len_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Sequence one item through squaring, root, add, leak and decision
   always_comb begin
      since_trig    = now_ff - last_trig_ff;
      acc_sum       = {1'b0, energy_ff} + {{(ENERGY_W+1-sed_pkg::ROOT_W){1'b0}}, root};
      fire          = !cool_ff && (leaked_ff > thresh_ff);

      state_in      = state_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      cool_in       = cool_ff;
      base_in       = base_ff;
      leaked_in     = leaked_ff;
      energy_in     = energy_ff;
      last_trig_in  = last_trig_ff;
      has_trig_in   = has_trig_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_state_in  = rsp_state_ff;
      rsp_energy_in = rsp_energy_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in   = req_now;
               cnt_in   = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // Cooldown check on wrapped time difference
            cool_in = has_trig_ff && (since_trig < cool_len_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == sed_pkg::CNT_W'(sed_pkg::SQ_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sed_pkg::CNT_W'(sed_pkg::ROOT_STEPS)) begin
               cnt_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // Saturating add of the magnitude, skipped during cooldown
            if (cool_ff) begin
               base_in = energy_ff;
            end else if (acc_sum[ENERGY_W]) begin
               base_in = '1;
            end else begin
               base_in = acc_sum[ENERGY_W-1:0];
            end
            state_in = ST_LEAK;
         end
         ST_LEAK: begin
            // Leak clamped at zero
            leaked_in = (base_ff > leak_amount) ? (base_ff - leak_amount) : '0;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Hold until the output register is free
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (fire) begin
                  energy_in     = '0;
                  last_trig_in  = now_ff;
                  has_trig_in   = 1'b1;
                  rsp_state_in  = sed_pkg::TRIG_FIRED;
                  rsp_energy_in = '0;
               end else begin
                  energy_in     = leaked_ff;
                  rsp_energy_in = leaked_ff;
                  rsp_state_in  = (!cool_ff && (leaked_ff != '0)) ?
                                  sed_pkg::TRIG_ONGOING : sed_pkg::TRIG_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         last_trig_ff <= '0;
         has_trig_ff  <= 1'b0;
         thresh_ff    <= sed_pkg::THRESHOLD_RESET;
         decay_ff     <= sed_pkg::DECAY_RESET;
         cool_len_ff  <= sed_pkg::COOLDOWN_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         last_trig_ff <= last_trig_in;
         has_trig_ff  <= has_trig_in;
         thresh_ff    <= thresh_in;
         decay_ff     <= decay_in;
         cool_len_ff  <= cool_len_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      cool_ff       <= cool_in;
      base_ff       <= base_in;
      leaked_ff     <= leaked_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_energy_ff <= rsp_energy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(sed_pkg::RSP_DATA_W-ENERGY_W-sed_pkg::STATE_W){1'b0}},
                        rsp_energy_ff, rsp_state_ff};

   // Checks
   `SED_ASSERT(a_busy_after_accept, clock, reset, req_fire |=> !req_tready)
   `SED_ASSERT(a_fire_clears_energy, clock, reset, rsp_tvalid && (rsp_state_ff == sed_pkg::TRIG_FIRED) |-> rsp_energy_ff == '0)
   `SED_ASSERT(a_fire_records_time, clock, reset, out_load && fire |=> has_trig_ff && (last_trig_ff == $past(now_ff)))
   `SED_ASSERT_NEVER(a_no_fire_in_cooldown, clock, reset, out_load && cool_ff && fire)

endmodule

// File: hw/rtl/sed_mul_serial.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per step.
// ----------------------------------------------------------------------------
module sed_mul_serial #(
   parameter int WIDTH = sed_pkg::VEL_W
) (
   input  logic                   clock,
   input  sed_pkg::seq_ctl_type   ctl,
   input  logic [WIDTH-1:0]       multiplicand,
   input  logic [WIDTH-1:0]       multiplier,
   output logic [2*WIDTH-1:0]     product
);

   logic [WIDTH-1:0]   mcand_ff, mcand_in;
   logic [2*WIDTH-1:0] prod_ff, prod_in;
   logic [WIDTH:0]     part_sum;

   // Add the multiplicand into the upper half when the low bit is set
   always_comb begin
      part_sum = {1'b0, prod_ff[2*WIDTH-1:WIDTH]}
               + (prod_ff[0] ? {1'b0, mcand_ff} : {(WIDTH+1){1'b0}});
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (ctl.load) begin
         mcand_in = multiplicand;
         prod_in  = {{WIDTH{1'b0}}, multiplier};
      end else if (ctl.step) begin
         prod_in = {part_sum, prod_ff[WIDTH-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign product = prod_ff;

endmodule

// File: hw/rtl/sed_isqrt_serial.sv
// ----------------------------------------------------------------------------
// Serial square root
// Restoring digit-by-digit root of (radicand << 16), one root bit per step.
// ----------------------------------------------------------------------------
module sed_isqrt_serial (
   input  logic                          clock,
   input  sed_pkg::seq_ctl_type          ctl,
   input  logic [sed_pkg::SQ_W-1:0]      radicand,
   output logic [sed_pkg::ROOT_W-1:0]    root
);

   localparam int REM_W   = sed_pkg::ROOT_W + 1;
   localparam int TRIAL_W = sed_pkg::ROOT_W + 3;

   logic [sed_pkg::SQ_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [sed_pkg::ROOT_W-1:0] q_ff, q_in;
   logic [TRIAL_W-1:0]         rem_shift;
   logic [TRIAL_W-1:0]         trial;
   logic [TRIAL_W-1:0]         diff;

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      rem_shift = {rem_ff, rad_ff[sed_pkg::SQ_W-1 -: 2]};
      trial     = {1'b0, q_ff, 2'b01};
      diff      = rem_shift - trial;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      if (ctl.load) begin
         rad_in = radicand;
         rem_in = '0;
         q_in   = '0;
      end else if (ctl.step) begin
         // Low radicand bits past the stored word are zero
         rad_in = {rad_ff[sed_pkg::SQ_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in = diff[REM_W-1:0];
            q_in   = {q_ff[sed_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[REM_W-1:0];
            q_in   = {q_ff[sed_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign root = q_ff;

endmodule
